>>> rtl/pbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pbr_pkg;

	localparam int NUM_SLOTS_DEF   = 8;
	localparam int MAX_PACKETS_DEF = 1024;

	// Fixed field widths
	localparam int TS_W    = 64;
	localparam int DIVR_W  = 28;
	localparam int DIVN_W  = 7;
	localparam int EPOCH_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ANT_OFF  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHN_OFF  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOT_ANT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOT_CHN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PART_ANT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PART_CHN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PART_SMP = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SMP_SLOT = 3'd7;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RECV = 2'd1,
		PH_COMP = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		V_PLACED   = 2'd0,
		V_EVICTED  = 2'd1,
		V_LOST     = 2'd2,
		V_RELEASED = 2'd3
	} verdict_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_DUR,
		ST_DIVGO,
		ST_DIVW,
		ST_MULA,
		ST_MULB,
		ST_MULC,
		ST_MULD,
		ST_LOOKUP,
		ST_SWEEP,
		ST_READ,
		ST_UPDATE
	} state_t;

	typedef enum logic [2:0] {
		OP_BLOCK,
		OP_TIME,
		OP_ANT,
		OP_CHN,
		OP_SLOTS_C,
		OP_SLOTS_A
	} div_op_t;

	typedef struct packed {
		logic                start;
		logic [TS_W-1:0]     dividend;
		logic [DIVR_W-1:0]   divisor;
		logic [DIVN_W-1:0]   nbits;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [TS_W-1:0]     quotient;
		logic [DIVR_W-1:0]   remainder;
	} div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/pbr_div.sv
`timescale 1ns / 1ps
`default_nettype none
module pbr_div import pbr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [TS_W-1:0]   q_q;
	logic [DIVR_W-1:0] r_q;
	logic [DIVR_W-1:0] d_q;
	logic [DIVN_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIVR_W:0]   rr;
	logic              ge;

	// one quotient bit per cycle, restoring
	assign rr = {r_q, q_q[TS_W-1]};
	assign ge = rr >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.nbits;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIVN_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.dividend << (DIVN_W'(TS_W) - req.nbits);
			r_q <= '0;
			d_q <= req.divisor;
		end else if (run_q) begin
			q_q <= {q_q[TS_W-2:0], ge};
			r_q <= ge ? DIVR_W'(rr - {1'b0, d_q}) : DIVR_W'(rr);
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = q_q;
	assign rsp.remainder = r_q;

endmodule
`default_nettype wire

>>> rtl/packet_block_reassembly_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Packet block reassembly. Pulse start while busy is low to hand in one beat:
// a packet (command 0) or a slot release (command 1). Exactly one result beat
// follows, shown for a single cycle with done high; the receiver cannot stall
// it, so sample it on that cycle. A release is decided in the decode state and
// its beat leaves through the done register. For a packet the shared divider
// produces one quotient bit per cycle and runs six divisions in turn (64 bits
// for the block index, 28 for the sample slot, 16 + 16 + 13 + 11 for the window
// geometry), followed by the multiply stages MULA to MULD, the slot lookup and
// one read-modify-write of the presence memory. Presence bits live in one
// synchronous memory tagged with a per-slot epoch, so taking or releasing a slot
// costs no clearing; once every 255 reuses of a slot its memory region of
// MAX_PACKETS rounded up to a power of two entries is swept. After reset the
// whole memory is swept once; busy stays high until then. Write configuration
// only while busy is low.
module packet_block_reassembly_core import pbr_pkg::*; #(
	parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
	parameter int MAX_PACKETS = MAX_PACKETS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  command,
	input  wire logic [15:0]           antenna_id,
	input  wire logic [15:0]           channel_number,
	input  wire logic [63:0]           timestamp,
	input  wire logic [2:0]            release_slot,
	output logic                       done,
	output logic [1:0]                 verdict,
	output logic [2:0]                 slot,
	output logic [9:0]                 packet_index,
	output logic [63:0]                block_index,
	output logic                       stole_slot,
	output logic                       block_complete
);

	localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int IW    = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
	localparam int AW    = SW + IW;
	localparam int DEPTH = 1 << AW;
	localparam int CW    = $clog2(MAX_PACKETS + 1);
	localparam logic [34:0] MAXP = 35'(MAX_PACKETS);
	localparam logic [41:0] MAXI = 42'(MAX_PACKETS);

	// Configuration registers
	logic [15:0] ant_off_q, chn_off_q;
	logic [10:0] tot_ant_q, part_ant_q, smp_slot_q;
	logic [12:0] tot_chn_q, part_chn_q;
	logic [16:0] part_smp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ant_off_q  <= '0;
			chn_off_q  <= '0;
			tot_ant_q  <= 11'd1;
			tot_chn_q  <= 13'd1;
			part_ant_q <= 11'd1;
			part_chn_q <= 13'd1;
			part_smp_q <= 17'd1;
			smp_slot_q <= 11'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ANT_OFF:  ant_off_q  <= cfg_data[15:0];
				CFG_CHN_OFF:  chn_off_q  <= cfg_data[15:0];
				CFG_TOT_ANT:  tot_ant_q  <= cfg_data[10:0];
				CFG_TOT_CHN:  tot_chn_q  <= cfg_data[12:0];
				CFG_PART_ANT: part_ant_q <= cfg_data[10:0];
				CFG_PART_CHN: part_chn_q <= cfg_data[12:0];
				CFG_PART_SMP: part_smp_q <= cfg_data[16:0];
				CFG_SMP_SLOT: smp_slot_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Zero divisors act as one
	logic [10:0] pa, ss;
	logic [12:0] pc;
	logic [16:0] ps;
	assign pa = (part_ant_q == '0) ? 11'd1 : part_ant_q;
	assign pc = (part_chn_q == '0) ? 13'd1 : part_chn_q;
	assign ps = (part_smp_q == '0) ? 17'd1 : part_smp_q;
	assign ss = (smp_slot_q == '0) ? 11'd1 : smp_slot_q;

	state_t state_q, state_d, ret_q;

	// Captured beat
	logic        cmd_q;
	logic [15:0] ant_q, chn_q, ant_rel_q, chn_rel_q;
	logic [63:0] ts_q;
	logic [2:0]  rel_q;

	// Datapath registers
	logic [DIVR_W-1:0] dur_q, rem_q;
	logic [63:0]       blk_q;
	logic [10:0]       t_q, q6_q;
	logic [15:0]       a_q, c_q;
	logic [12:0]       sc_q;
	logic [28:0]       p1_q;
	logic [39:0]       p1s_q;
	logic [26:0]       p2_q;
	logic [23:0]       ppb1_q;
	logic [34:0]       ppb_q;
	logic [41:0]       idx_q;
	div_op_t           dop_q;

	// Slot table
	phase_t          phase_q  [NUM_SLOTS];
	logic [63:0]     sblk_q   [NUM_SLOTS];
	logic [SW-1:0]   age_q    [NUM_SLOTS];
	logic [SW-1:0]   idle_q   [NUM_SLOTS];
	logic [CW-1:0]   pcnt_q   [NUM_SLOTS];
	logic [EPOCH_W-1:0] epoch_q [NUM_SLOTS];
	logic [SW:0]     recv_cnt_q, idle_cnt_q;
	logic [SW-1:0]   s_q;
	logic            stole_q;
	logic [AW-1:0]   swp_q;

	// Presence memory
	logic [EPOCH_W-1:0] pres_mem [DEPTH];
	logic [EPOCH_W-1:0] rd_s2;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [EPOCH_W-1:0] mem_wd;
	logic [AW-1:0]      rd_addr;

	assign rd_addr = {s_q, idx_q[IW-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pres_mem[mem_wa] <= mem_wd;
		end
		rd_s2 <= pres_mem[rd_addr];
	end

	// Divider
	div_req_t dreq;
	div_rsp_t drsp;

	pbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_comb begin
		dreq.start    = (state_q == ST_DIVGO);
		dreq.dividend = '0;
		dreq.divisor  = DIVR_W'(1);
		dreq.nbits    = DIVN_W'(1);
		unique case (dop_q)
			OP_BLOCK: begin
				dreq.dividend = ts_q;
				dreq.divisor  = dur_q;
				dreq.nbits    = DIVN_W'(64);
			end
			OP_TIME: begin
				dreq.dividend = 64'(rem_q);
				dreq.divisor  = DIVR_W'(ps);
				dreq.nbits    = DIVN_W'(DIVR_W);
			end
			OP_ANT: begin
				dreq.dividend = 64'(ant_rel_q);
				dreq.divisor  = DIVR_W'(pa);
				dreq.nbits    = DIVN_W'(16);
			end
			OP_CHN: begin
				dreq.dividend = 64'(chn_rel_q);
				dreq.divisor  = DIVR_W'(pc);
				dreq.nbits    = DIVN_W'(16);
			end
			OP_SLOTS_C: begin
				dreq.dividend = 64'(tot_chn_q);
				dreq.divisor  = DIVR_W'(pc);
				dreq.nbits    = DIVN_W'(13);
			end
			OP_SLOTS_A: begin
				dreq.dividend = 64'(tot_ant_q);
				dreq.divisor  = DIVR_W'(pa);
				dreq.nbits    = DIVN_W'(11);
			end
			default: ;
		endcase
	end

	// Window check
	logic [15:0] ant_d, chn_d;
	logic        win_out;
	assign ant_d = ant_q - ant_off_q;
	assign chn_d = chn_q - chn_off_q;
	assign win_out = (ant_q < ant_off_q) || (17'(ant_d) >= 17'(tot_ant_q)) ||
		(chn_q < chn_off_q) || (17'(chn_d) >= 17'(tot_chn_q));

	// Release check
	logic [SW-1:0] r_idx;
	logic          rel_ok;
	assign r_idx  = SW'(rel_q);
	assign rel_ok = (32'(rel_q) < NUM_SLOTS) && (phase_q[r_idx] == PH_COMP);

	// Lookup among receiving slots, lowest index first
	logic          hit;
	logic [SW-1:0] hit_s;
	always_comb begin
		hit   = 1'b0;
		hit_s = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!hit && phase_q[i] == PH_RECV && sblk_q[i] == blk_q) begin
				hit   = 1'b1;
				hit_s = SW'(i);
			end
		end
	end

	logic          idle_any, recv_any, lost, idx_big;
	logic [SW-1:0] s_new;
	assign idle_any = (idle_cnt_q != '0);
	assign recv_any = (recv_cnt_q != '0);
	assign lost     = !hit && !idle_any && !recv_any;
	assign idx_big  = (idx_q >= MAXI);
	assign s_new    = hit ? hit_s : (idle_any ? idle_q[0] : age_q[0]);

	// List reshuffles
	logic [SW-1:0] idle_pop [NUM_SLOTS];
	logic [SW-1:0] age_rot  [NUM_SLOTS];
	logic [SW-1:0] age_del  [NUM_SLOTS];
	logic [SW:0]   del_pos;
	logic          del_fnd;
	always_comb begin
		del_pos = '0;
		del_fnd = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!del_fnd && age_q[i] == s_q && (SW + 1)'(i) < recv_cnt_q) begin
				del_fnd = 1'b1;
				del_pos = (SW + 1)'(i);
			end
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			idle_pop[i] = (i + 1 < NUM_SLOTS) ? idle_q[i + 1] : idle_q[i];
			if ((SW + 1)'(i + 1) < recv_cnt_q) begin
				age_rot[i] = age_q[(i + 1) % NUM_SLOTS];
			end else if ((SW + 1)'(i + 1) == recv_cnt_q) begin
				age_rot[i] = age_q[0];
			end else begin
				age_rot[i] = age_q[i];
			end
			if ((SW + 1)'(i) >= del_pos && i + 1 < NUM_SLOTS) begin
				age_del[i] = age_q[i + 1];
			end else begin
				age_del[i] = age_q[i];
			end
		end
	end

	// Presence update
	logic          present, complete;
	logic [CW-1:0] cnt_new;
	logic [34:0]   ppb_cap;
	assign present  = (rd_s2 == epoch_q[s_q]);
	assign cnt_new  = pcnt_q[s_q] + 1'b1;
	assign ppb_cap  = (ppb_q > MAXP) ? MAXP : ppb_q;
	assign complete = !present && (35'(cnt_new) == ppb_cap);

	logic rel_wrap, new_wrap, swp_last;
	assign rel_wrap = (epoch_q[r_idx] == '1);
	assign new_wrap = !hit && (epoch_q[s_new] == '1);
	assign swp_last = (state_q == ST_INIT) ? (swp_q == '1) : (swp_q[IW-1:0] == '1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT:   if (swp_last) state_d = ST_IDLE;
			ST_IDLE:   if (start) state_d = ST_DECODE;
			ST_DECODE: begin
				if (cmd_q) begin
					state_d = (rel_ok && rel_wrap) ? ST_SWEEP : ST_IDLE;
				end else begin
					state_d = win_out ? ST_IDLE : ST_DUR;
				end
			end
			ST_DUR:    state_d = ST_DIVGO;
			ST_DIVGO:  state_d = ST_DIVW;
			ST_DIVW: begin
				if (drsp.done) state_d = (dop_q == OP_SLOTS_A) ? ST_MULA : ST_DIVGO;
			end
			ST_MULA:   state_d = ST_MULB;
			ST_MULB:   state_d = ST_MULC;
			ST_MULC:   state_d = ST_MULD;
			ST_MULD:   state_d = ST_LOOKUP;
			ST_LOOKUP: begin
				if (idx_big || lost) begin
					state_d = ST_IDLE;
				end else begin
					state_d = new_wrap ? ST_SWEEP : ST_READ;
				end
			end
			ST_SWEEP:  if (swp_last) state_d = ret_q;
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_IDLE;
			default:   state_d = ST_INIT;
		endcase
	end

	// Outputs: result beat and memory write port
	logic        emit;
	verdict_t    res_v;
	logic [2:0]  res_slot;
	logic [9:0]  res_pidx;
	logic [63:0] res_blk;
	logic        res_stole, res_done;
	always_comb begin
		emit      = 1'b0;
		res_v     = V_PLACED;
		res_slot  = '0;
		res_pidx  = '0;
		res_blk   = '0;
		res_stole = 1'b0;
		res_done  = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = swp_q;
		mem_wd    = '0;
		unique case (state_q)
			ST_INIT, ST_SWEEP: mem_we = 1'b1;
			ST_DECODE: begin
				if (cmd_q) begin
					emit     = 1'b1;
					res_slot = rel_q;
					if (rel_ok) begin
						res_v   = V_RELEASED;
						res_blk = sblk_q[r_idx];
					end else begin
						res_v   = V_EVICTED;
					end
				end else if (win_out) begin
					emit  = 1'b1;
					res_v = V_EVICTED;
				end
			end
			ST_LOOKUP: begin
				if (idx_big) begin
					emit     = 1'b1;
					res_v    = V_EVICTED;
					res_pidx = idx_q[9:0];
				end else if (lost) begin
					emit     = 1'b1;
					res_v    = V_LOST;
					res_pidx = idx_q[9:0];
					res_blk  = blk_q;
				end
			end
			ST_UPDATE: begin
				emit      = 1'b1;
				res_v     = V_PLACED;
				res_slot  = 3'(s_q);
				res_pidx  = idx_q[9:0];
				res_blk   = blk_q;
				res_stole = stole_q;
				res_done  = complete;
				mem_we    = !present;
				mem_wa    = rd_addr;
				mem_wd    = epoch_q[s_q];
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// Control state and slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			ret_q      <= ST_IDLE;
			swp_q      <= '0;
			dop_q      <= OP_BLOCK;
			recv_cnt_q <= '0;
			idle_cnt_q <= (SW + 1)'(NUM_SLOTS);
			done       <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				phase_q[i] <= PH_IDLE;
				age_q[i]   <= '0;
				idle_q[i]  <= SW'(i);
				pcnt_q[i]  <= '0;
				epoch_q[i] <= EPOCH_W'(1);
			end
		end else begin
			state_q <= state_d;
			done    <= emit;
			unique case (state_q)
				ST_INIT: swp_q <= swp_q + 1'b1;
				ST_SWEEP: swp_q <= swp_q + 1'b1;
				ST_DECODE: begin
					dop_q <= OP_BLOCK;
					if (cmd_q && rel_ok) begin
						// return the slot to the idle list, retire its presence bits
						phase_q[r_idx] <= PH_IDLE;
						pcnt_q[r_idx]  <= '0;
						epoch_q[r_idx] <= rel_wrap ? EPOCH_W'(1) : epoch_q[r_idx] + 1'b1;
						swp_q          <= {r_idx, {IW{1'b0}}};
						ret_q          <= ST_IDLE;
						if (idle_cnt_q < (SW + 1)'(NUM_SLOTS)) begin
							idle_q[idle_cnt_q[SW-1:0]] <= r_idx;
							idle_cnt_q <= idle_cnt_q + 1'b1;
						end
					end
				end
				ST_DIVW: if (drsp.done) dop_q <= div_op_t'(dop_q + 1'b1);
				ST_LOOKUP: begin
					if (!idx_big && !lost) begin
						s_q     <= s_new;
						stole_q <= !hit && !idle_any;
						if (!hit) begin
							phase_q[s_new] <= PH_RECV;
							pcnt_q[s_new]  <= '0;
							epoch_q[s_new] <= new_wrap ? EPOCH_W'(1) : epoch_q[s_new] + 1'b1;
							swp_q          <= {s_new, {IW{1'b0}}};
							ret_q          <= ST_READ;
							if (idle_any) begin
								// take the front idle slot, append it to the age order
								idle_q     <= idle_pop;
								idle_cnt_q <= idle_cnt_q - 1'b1;
								age_q[recv_cnt_q[SW-1:0]] <= s_new;
								recv_cnt_q <= recv_cnt_q + 1'b1;
							end else begin
								// steal the oldest: it moves to the back of the age order
								age_q <= age_rot;
							end
						end
					end
				end
				ST_UPDATE: begin
					if (!present) begin
						pcnt_q[s_q] <= cnt_new;
						if (complete) begin
							phase_q[s_q] <= PH_COMP;
							age_q        <= age_del;
							recv_cnt_q   <= recv_cnt_q - 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= command;
			ant_q <= antenna_id;
			chn_q <= channel_number;
			ts_q  <= timestamp;
			rel_q <= release_slot;
		end
		if (state_q == ST_DECODE) begin
			ant_rel_q <= ant_d;
			chn_rel_q <= chn_d;
		end
		if (state_q == ST_DUR) begin
			dur_q <= DIVR_W'(ps * ss);
		end
		if (state_q == ST_DIVW && drsp.done) begin
			unique case (dop_q)
				OP_BLOCK: begin
					blk_q <= drsp.quotient;
					rem_q <= drsp.remainder;
				end
				OP_TIME:    t_q  <= drsp.quotient[10:0];
				OP_ANT:     a_q  <= drsp.quotient[15:0];
				OP_CHN:     c_q  <= drsp.quotient[15:0];
				OP_SLOTS_C: sc_q <= drsp.quotient[12:0];
				OP_SLOTS_A: q6_q <= drsp.quotient[10:0];
				default: ;
			endcase
		end
		if (state_q == ST_MULA) begin
			p1_q <= 29'(a_q * sc_q);
		end
		if (state_q == ST_MULB) begin
			p1s_q <= 40'(p1_q * ss);
			p2_q  <= 27'(c_q * ss);
		end
		if (state_q == ST_MULC) begin
			ppb1_q <= 24'(q6_q * sc_q);
			idx_q  <= 42'(p1s_q) + 42'(p2_q) + 42'(t_q);
		end
		if (state_q == ST_MULD) begin
			ppb_q <= 35'(ppb1_q * ss);
		end
		if (state_q == ST_LOOKUP && !idx_big && !lost && !hit) begin
			sblk_q[s_new] <= blk_q;
		end
		if (emit) begin
			verdict        <= res_v;
			slot           <= res_slot;
			packet_index   <= res_pidx;
			block_index    <= res_blk;
			stole_slot     <= res_stole;
			block_complete <= res_done;
		end
	end

endmodule
`default_nettype wire

>>> tb/pbr_checker.sv
`timescale 1ns / 1ps
module pbr_checker import pbr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire logic                  command,
	input  wire logic [15:0]           antenna_id,
	input  wire logic [15:0]           channel_number,
	input  wire logic [63:0]           timestamp,
	input  wire logic [2:0]            release_slot,
	input  wire logic                  done,
	input  wire logic [1:0]            verdict,
	input  wire logic [2:0]            slot,
	input  wire logic [9:0]            packet_index,
	input  wire logic [63:0]           block_index,
	input  wire logic                  stole_slot,
	input  wire logic                  block_complete,
	output int                         pending,
	output int                         errors
);

	localparam int SLOTS = 8;
	localparam int MAXP  = 1024;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [2:0]  slot;
		logic [9:0]  pidx;
		logic [63:0] bidx;
		logic        stole;
		logic        complete;
	} beat_t;

	localparam logic [16:0] REG_MASK [8] = '{17'hFFFF, 17'hFFFF, 17'h7FF, 17'h1FFF,
		17'h7FF, 17'h1FFF, 17'h1FFFF, 17'h7FF};

	logic [16:0]    cfg_reg [8];
	phase_t         phase [SLOTS];
	logic [63:0]    held_block [SLOTS];
	logic [MAXP-1:0] present [SLOTS];
	int             unique_count [SLOTS];
	int             age_q [$];
	int             idle_q [$];
	beat_t          expect_q [$];

	function automatic logic [63:0] at_least_one(input logic [16:0] v);
		return (v == 0) ? 64'd1 : 64'(v);
	endfunction

	task automatic drop_from_age(input int s);
		for (int i = 0; i < age_q.size(); i++) begin
			if (age_q[i] == s) begin
				age_q.delete(i);
				break;
			end
		end
	endtask

	task automatic predict_beat(input logic cmd, input logic [15:0] ant_in,
			input logic [15:0] chn_in, input logic [63:0] ts, input logic [2:0] rel);
		logic [63:0] pa, pc, ps, ss, ant, chn, dur, blk, a, c, t, slots_c, idx, ppb;
		int s;
		bit found;
		bit stole;
		beat_t r;
		r = '0;
		found = 0;
		stole = 0;
		pa = at_least_one(cfg_reg[CFG_PART_ANT]);
		pc = at_least_one(cfg_reg[CFG_PART_CHN]);
		ps = at_least_one(cfg_reg[CFG_PART_SMP]);
		ss = at_least_one(cfg_reg[CFG_SMP_SLOT]);
		if (cmd) begin
			// release: only a computing slot goes back to idle
			r.slot = rel;
			if (phase[rel] != PH_COMP) begin
				r.verdict = V_EVICTED;
			end else begin
				phase[rel] = PH_IDLE;
				present[rel] = '0;
				unique_count[rel] = 0;
				idle_q.push_back(int'(rel));
				r.verdict = V_RELEASED;
				r.bidx = held_block[rel];
			end
			expect_q.push_back(r);
			return;
		end
		ant = 64'(ant_in);
		chn = 64'(chn_in);
		if (ant < 64'(cfg_reg[CFG_ANT_OFF]) || ant - 64'(cfg_reg[CFG_ANT_OFF]) >= 64'(cfg_reg[CFG_TOT_ANT])
				|| chn < 64'(cfg_reg[CFG_CHN_OFF])
				|| chn - 64'(cfg_reg[CFG_CHN_OFF]) >= 64'(cfg_reg[CFG_TOT_CHN])) begin
			r.verdict = V_EVICTED;
			expect_q.push_back(r);
			return;
		end
		ant = ant - 64'(cfg_reg[CFG_ANT_OFF]);
		chn = chn - 64'(cfg_reg[CFG_CHN_OFF]);
		dur = ss * ps;
		blk = ts / dur;
		t = (ts % dur) / ps;
		a = ant / pa;
		c = chn / pc;
		slots_c = 64'(cfg_reg[CFG_TOT_CHN]) / pc;
		idx = a * slots_c * ss + c * ss + t;
		ppb = (64'(cfg_reg[CFG_TOT_ANT]) / pa) * slots_c * ss;
		if (ppb > MAXP)
			ppb = MAXP;
		r.pidx = idx[9:0];
		if (idx >= MAXP) begin
			// index beyond the block: evict, leave the slots alone
			r.verdict = V_EVICTED;
			expect_q.push_back(r);
			return;
		end
		s = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (phase[i] == PH_RECV && held_block[i] == blk) begin
				s = i;
				found = 1;
				break;
			end
		end
		if (!found) begin
			if (idle_q.size() == 0) begin
				if (age_q.size() == 0) begin
					// every slot computes: packet is lost
					r.verdict = V_LOST;
					r.bidx = blk;
					expect_q.push_back(r);
					return;
				end
				// steal the oldest receiving slot
				s = age_q.pop_front();
				phase[s] = PH_IDLE;
				idle_q.push_back(s);
				stole = 1;
			end
			s = idle_q.pop_front();
			phase[s] = PH_RECV;
			held_block[s] = blk;
			present[s] = '0;
			unique_count[s] = 0;
			age_q.push_back(s);
		end
		r.verdict = V_PLACED;
		r.slot = s[2:0];
		r.bidx = blk;
		r.stole = stole;
		if (!present[s][idx[9:0]]) begin
			present[s][idx[9:0]] = 1'b1;
			unique_count[s]++;
			if (64'(unique_count[s]) == ppb) begin
				drop_from_age(s);
				phase[s] = PH_COMP;
				r.complete = 1'b1;
			end
		end
		expect_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_t e;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				cfg_reg[i] = (i < 2) ? 17'd0 : 17'd1;
			for (int i = 0; i < SLOTS; i++) begin
				phase[i] = PH_IDLE;
				held_block[i] = '0;
				present[i] = '0;
				unique_count[i] = 0;
			end
			age_q.delete();
			idle_q.delete();
			for (int i = 0; i < SLOTS; i++)
				idle_q.push_back(i);
			expect_q.delete();
			errors = 0;
		end else begin
			if (cfg_we)
				cfg_reg[cfg_index] = cfg_data & REG_MASK[cfg_index];
			// check the result beat before queueing a new prediction
			if (done) begin
				if (expect_q.size() == 0) begin
					$display("%0t: result beat with nothing expected, verdict %0d slot %0d",
						$time, verdict, slot);
					errors++;
				end else begin
					e = expect_q.pop_front();
					if (verdict !== e.verdict) begin
						$display("%0t: verdict expected %0d got %0d", $time, e.verdict, verdict);
						errors++;
					end
					if (slot !== e.slot) begin
						$display("%0t: slot expected %0d got %0d", $time, e.slot, slot);
						errors++;
					end
					if (packet_index !== e.pidx) begin
						$display("%0t: packet_index expected %0d got %0d",
							$time, e.pidx, packet_index);
						errors++;
					end
					if (block_index !== e.bidx) begin
						$display("%0t: block_index expected %h got %h",
							$time, e.bidx, block_index);
						errors++;
					end
					if (stole_slot !== e.stole) begin
						$display("%0t: stole_slot expected %0d got %0d",
							$time, e.stole, stole_slot);
						errors++;
					end
					if (block_complete !== e.complete) begin
						$display("%0t: block_complete expected %0d got %0d",
							$time, e.complete, block_complete);
						errors++;
					end
				end
			end
			if (start && !busy)
				predict_beat(command, antenna_id, channel_number, timestamp, release_slot);
		end
		pending = expect_q.size();
	end

	initial begin
		pending = 0;
		errors = 0;
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import pbr_pkg::*;

	localparam longint CYCLE_LIMIT = 3000000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  start;
	logic                  busy;
	logic                  command;
	logic [15:0]           antenna_id;
	logic [15:0]           channel_number;
	logic [63:0]           timestamp;
	logic [2:0]            release_slot;
	logic                  done;
	logic [1:0]            verdict;
	logic [2:0]            slot;
	logic [9:0]            packet_index;
	logic [63:0]           block_index;
	logic                  stole_slot;
	logic                  block_complete;
	int                    pending;
	int                    errors;
	longint                cycles;

	// window geometry as last written, used to aim packets into the window
	logic [16:0] geo [8];
	int          gap_max;
	int          release_pct;
	logic [63:0] block_base;

	packet_block_reassembly_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .command(command),
		.antenna_id(antenna_id), .channel_number(channel_number), .timestamp(timestamp),
		.release_slot(release_slot), .done(done), .verdict(verdict), .slot(slot),
		.packet_index(packet_index), .block_index(block_index), .stole_slot(stole_slot),
		.block_complete(block_complete)
	);

	pbr_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .command(command),
		.antenna_id(antenna_id), .channel_number(channel_number), .timestamp(timestamp),
		.release_slot(release_slot), .done(done), .verdict(verdict), .slot(slot),
		.packet_index(packet_index), .block_index(block_index), .stole_slot(stole_slot),
		.block_complete(block_complete), .pending(pending), .errors(errors)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** packet_block_reassembly_core: FAILED **");
			$finish;
		end
	end

	// Hand one beat in: hold start low for a random gap, then hold it high until
	// an edge sees busy low. With no gap, start stays high into the next beat.
	task automatic send_beat(input logic cmd, input logic [15:0] ant, input logic [15:0] chn,
			input logic [63:0] ts, input logic [2:0] rel);
		int gap;
		gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		command        <= cmd;
		antenna_id     <= ant;
		channel_number <= chn;
		timestamp      <= ts;
		release_slot   <= rel;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Wait out every outstanding result, then let the core settle.
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_geometry(input logic [16:0] v [8]);
		for (int i = 0; i < 8; i++) begin
			do
				@(posedge clk);
			while (busy);
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= v[i];
			geo[i] = v[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] nz(input logic [16:0] v);
		return (v == 0) ? 64'd1 : 64'(v);
	endfunction

	// Mostly well-formed packets on a handful of nearby blocks so slots fill,
	// complete and get stolen; the rest is releases and raw noise.
	task automatic random_beat;
		int pick;
		logic [63:0] ps, ss, blk, ts;
		logic [15:0] ant, chn;
		pick = $urandom_range(0, 99);
		ps = nz(geo[CFG_PART_SMP]);
		ss = nz(geo[CFG_SMP_SLOT]);
		if (pick < release_pct) begin
			send_beat(1'b1, 16'($urandom), 16'($urandom), {$urandom, $urandom},
				3'($urandom_range(0, 7)));
		end else if (pick < release_pct + 10) begin
			send_beat(1'b0, 16'($urandom), 16'($urandom), {$urandom, $urandom}, 3'($urandom));
		end else begin
			ant = 16'(geo[CFG_ANT_OFF] + $urandom_range(0, geo[CFG_TOT_ANT] - 1));
			chn = 16'(geo[CFG_CHN_OFF] + $urandom_range(0, geo[CFG_TOT_CHN] - 1));
			blk = block_base + 64'($urandom_range(0, 10));
			ts = blk * ss * ps + 64'($urandom_range(0, 32'(ss - 1))) * ps
				+ 64'($urandom_range(0, 32'(ps - 1)));
			send_beat(1'b0, ant, chn, ts, 3'($urandom));
		end
	endtask

	task automatic random_phase(input int count);
		block_base  = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 99));
		gap_max     = ($urandom_range(0, 2) == 0) ? 0 : 9;
		release_pct = ($urandom_range(0, 1) == 0) ? 8 : 25;
		for (int i = 0; i < count; i++)
			random_beat();
		drain();
	endtask

	initial begin
		logic [16:0] g [8];
		arst_n         = 1'b0;
		cycles         = 0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		start          = 1'b0;
		command        = 1'b0;
		antenna_id     = '0;
		channel_number = '0;
		timestamp      = '0;
		release_slot   = '0;
		gap_max        = 9;
		release_pct    = 20;
		geo = '{17'd0, 17'd0, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset geometry: one packet per block, so each packet completes.
		for (int i = 0; i < 8; i++)
			send_beat(1'b0, 16'd0, 16'd0, 64'(i), 3'd0);
		send_beat(1'b0, 16'd0, 16'd0, 64'd100, 3'd0);      // every slot computes: lost
		send_beat(1'b0, 16'd1, 16'd0, 64'd5, 3'd0);        // antenna outside window
		send_beat(1'b0, 16'd0, 16'hFFFF, 64'd5, 3'd0);     // channel outside window
		send_beat(1'b1, 16'd0, 16'd0, 64'd0, 3'd3);        // release a computing slot
		send_beat(1'b1, 16'd0, 16'd0, 64'd0, 3'd3);        // same slot again: rejected
		send_beat(1'b0, 16'd0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7);
		for (int i = 0; i < 8; i++)
			send_beat(1'b1, 16'hFFFF, 16'hFFFF, '0, 3'(i));
		drain();

		// Small window, eight packets per block: duplicates and slot stealing.
		g = '{17'd100, 17'd200, 17'd4, 17'd6, 17'd2, 17'd3, 17'd5, 17'd2};
		write_geometry(g);
		send_beat(1'b0, 16'd101, 16'd205, 64'd13, 3'd0);
		send_beat(1'b0, 16'd101, 16'd205, 64'd13, 3'd0);   // duplicate packet
		for (int i = 0; i < 9; i++)
			send_beat(1'b0, 16'd100, 16'd200, 64'(i * 10 + 40), 3'd0);
		random_phase(250);

		// Widest geometry with the largest offsets.
		g = '{17'hFFFF, 17'hFFFF, 17'd1024, 17'd4096, 17'd1024, 17'd4096, 17'h10000, 17'd1024};
		write_geometry(g);
		random_phase(150);

		// Zero divisors behave as one.
		g = '{17'd0, 17'd0, 17'd3, 17'd2, 17'd0, 17'd0, 17'd0, 17'd0};
		write_geometry(g);
		random_phase(250);

		// Totals not a multiple of the packet extent.
		g = '{17'd7, 17'd9, 17'd5, 17'd7, 17'd2, 17'd3, 17'd1000, 17'd3};
		write_geometry(g);
		random_phase(250);

		// Many antennas: most indexes overflow the block.
		g = '{17'd0, 17'd0, 17'd1024, 17'd8, 17'd1, 17'd1, 17'd1, 17'd1};
		write_geometry(g);
		random_phase(200);

		// Back to a block that fills quickly.
		g = '{17'd0, 17'd0, 17'd2, 17'd2, 17'd1, 17'd1, 17'd3, 17'd2};
		write_geometry(g);
		random_phase(400);

		if (errors == 0)
			$display("** packet_block_reassembly_core: PASSED **");
		else
			$display("** packet_block_reassembly_core: FAILED **");
		$finish;
	end

endmodule
